/* rtl/u2u8_pkg.sv */
// Shared types and constants for the UTF-16 to UTF-8 vector encoder.
`default_nettype none

package u2u8_pkg;

  localparam int unsigned UnitCount = 8;
  localparam int unsigned ByteSlots = 24;
  localparam int unsigned SlotBits  = ByteSlots * 8;
  localparam int unsigned OffW      = 5;

  typedef struct packed {
    logic [15:0] unit_0;
    logic [15:0] unit_1;
    logic [15:0] unit_2;
    logic [15:0] unit_3;
    logic [15:0] unit_4;
    logic [15:0] unit_5;
    logic [15:0] unit_6;
    logic [15:0] unit_7;
  } u2u8_in_t;

  typedef struct packed {
    logic [63:0] bytes_low;
    logic [63:0] bytes_middle;
    logic [63:0] bytes_high;
    logic [4:0]  byte_count;
    logic        exceeded;
  } u2u8_out_t;

  typedef struct packed {
    logic [23:0] seq;
    logic [1:0]  len;
  } u2u8_lane_t;

  typedef struct packed {
    logic            kill;
    logic [OffW-1:0] total;
  } u2u8_ctl_t;

endpackage

`default_nettype wire

/* rtl/u2u8_lane.sv */
// One encoding lane: turns a UTF-16 code unit into a UTF-8 sequence and its length.
`default_nettype none

module u2u8_lane
  import u2u8_pkg::*;
(
  input  logic [15:0] unit_i,
  output u2u8_lane_t  lane_o
);

  always_comb begin
    if (unit_i < 16'h0080) begin
      lane_o.seq = {16'h0000, 1'b0, unit_i[6:0]};
      lane_o.len = 2'd1;
    end else if (unit_i < 16'h0800) begin
      lane_o.seq = {8'h00, 2'b10, unit_i[5:0], 3'b110, unit_i[10:6]};
      lane_o.len = 2'd2;
    end else begin
      lane_o.seq = {2'b10, unit_i[5:0], 2'b10, unit_i[11:6], 4'b1110, unit_i[15:12]};
      lane_o.len = 2'd3;
    end
  end

endmodule

`default_nettype wire

/* rtl/u2u8_merge.sv */
// Merge stage: scatters the lane sequences to their byte offsets and forms the result word.
`default_nettype none

module u2u8_merge
  import u2u8_pkg::*;
(
  input  u2u8_lane_t [UnitCount-1:0]           lanes_i,
  input  logic       [UnitCount-1:0][OffW-1:0] offs_i,
  input  u2u8_ctl_t                            ctl_i,
  output u2u8_out_t                            res_o
);

  logic [SlotBits-1:0] packed_bytes;

  always_comb begin
    packed_bytes = '0;
    for (int i = 0; i < UnitCount; i++) begin
      packed_bytes = packed_bytes |
        ({{(SlotBits-24){1'b0}}, lanes_i[i].seq} << {offs_i[i], 3'b000});
    end
    if (ctl_i.kill) begin
      res_o = '0;
      res_o.exceeded = 1'b1;
    end else begin
      res_o.bytes_low    = packed_bytes[63:0];
      res_o.bytes_middle = packed_bytes[127:64];
      res_o.bytes_high   = packed_bytes[191:128];
      res_o.byte_count   = ctl_i.total;
      res_o.exceeded     = 1'b0;
    end
  end

endmodule

`default_nettype wire

/* rtl/utf16_to_utf8_vector_encoder_core.sv */
// Top level of the UTF-16 to UTF-8 vector encoder: eight encoding lanes and a merge stage.
`default_nettype none

// The block takes one word of eight UTF-16 code units in every cycle in which start is
// high; busy is always low. Each word gives exactly one result word on res_o, shown for
// one cycle with strobe_o high, once the word has passed both stages. The two stages are
// the eight encoding lanes with the running byte offsets, then the byte scatter into 24
// slots. The receiver cannot stall, so results must be taken when strobed.
module utf16_to_utf8_vector_encoder_core
  import u2u8_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start,
  output logic      busy,
  input  u2u8_in_t  in_i,
  input  logic      cfg_we_i,
  input  logic      cfg_wdata_i,
  output logic      strobe_o,
  output u2u8_out_t res_o
);

  logic limit_q;
  logic v1_q, v2_q;

  logic       [UnitCount-1:0][15:0]     units;
  u2u8_lane_t [UnitCount-1:0]           lanes_d, lanes_q;
  logic       [UnitCount-1:0][OffW-1:0] offs_d, offs_q;
  u2u8_ctl_t                            ctl_d, ctl_q;
  u2u8_out_t                            res_d, res_q;
  logic                                 big;

  assign busy  = 1'b0;
  assign units = {in_i.unit_7, in_i.unit_6, in_i.unit_5, in_i.unit_4,
                  in_i.unit_3, in_i.unit_2, in_i.unit_1, in_i.unit_0};

  for (genvar g = 0; g < UnitCount; g++) begin : g_lane
    u2u8_lane u_lane (
      .unit_i (units[g]),
      .lane_o (lanes_d[g])
    );
  end

  always_comb begin
    logic [OffW-1:0] run;
    run = '0;
    big = 1'b0;
    for (int i = 0; i < UnitCount; i++) begin
      offs_d[i] = run;
      run = run + OffW'(lanes_d[i].len);
      big = big | (lanes_d[i].len == 2'd3);
    end
    ctl_d.total = run;
    ctl_d.kill  = limit_q & big;
  end

  u2u8_merge u_merge (
    .lanes_i (lanes_q),
    .offs_i  (offs_q),
    .ctl_i   (ctl_q),
    .res_o   (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= 1'b0;
      v1_q    <= 1'b0;
      v2_q    <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        limit_q <= cfg_wdata_i;
      end
      v1_q <= start;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    lanes_q <= lanes_d;
    offs_q  <= offs_d;
    ctl_q   <= ctl_d;
    res_q   <= res_d;
  end

  assign strobe_o = v2_q;
  assign res_o    = res_q;

endmodule

`default_nettype wire

/* rtl/u2u8_checker.sv */
// Port-level checker for the encoder top level, with its bind statement.
`default_nettype none

module u2u8_checker
  import u2u8_pkg::*;
(
  input logic      clk_i,
  input logic      rst_ni,
  input logic      start,
  input logic      busy,
  input logic      strobe_o,
  input u2u8_out_t res_o
);

  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##2 strobe_o)
    else $error("A taken word did not give a result two cycles later.");

  a_no_orphan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o |-> $past(start, 2))
    else $error("A result appeared without a word taken two cycles before.");

  a_exceeded_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (strobe_o && res_o.exceeded) |-> (res_o.byte_count == 5'd0 &&
      res_o.bytes_low == 64'd0 && res_o.bytes_middle == 64'd0 && res_o.bytes_high == 64'd0))
    else $error("An exceeded result carried bytes.");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (strobe_o && !res_o.exceeded) |-> (res_o.byte_count >= 5'd8 && res_o.byte_count <= 5'd24))
    else $error("Byte count out of range for eight code units.");

  a_high_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (strobe_o && res_o.byte_count <= 5'd16) |-> res_o.bytes_high == 64'd0)
    else $error("Bytes past the byte count are not zero.");

endmodule

bind utf16_to_utf8_vector_encoder_core u2u8_checker u_u2u8_checker (
  .clk_i    (clk_i),
  .rst_ni   (rst_ni),
  .start    (start),
  .busy     (busy),
  .strobe_o (strobe_o),
  .res_o    (res_o)
);

`default_nettype wire

/* test/utf16_to_utf8_vector_encoder_core_tb.sv */
// Self-checking testbench for the UTF-16 to UTF-8 vector encoder core.
`timescale 1ns / 100ps

module utf16_to_utf8_vector_encoder_core_tb;
  import u2u8_pkg::*;

  localparam int unsigned ClkHalf     = 4;
  localparam int unsigned ResetCycles = 8;
  localparam int unsigned DrainCycles = 6;
  localparam int unsigned MaxReports  = 10;
  localparam logic [15:0] OneByteTop  = 16'h0080;
  localparam logic [15:0] TwoByteTop  = 16'h0800;
  localparam logic [15:0] UnitMax     = 16'hFFFF;

  typedef logic [15:0] group_t [UnitCount];

  class utf8_scoreboard;
    u2u8_out_t   encoded_q[$];
    bit          limit_on;
    int unsigned words_seen;
    int unsigned words_checked;
    int unsigned limited_words;
    int unsigned flagged_words;
    int unsigned full_words;
    int unsigned mismatches;

    function u2u8_out_t encode_group(u2u8_in_t w);
      logic [15:0]         u [UnitCount];
      logic [SlotBits-1:0] slots;
      int unsigned         pos;
      bit                  big;
      u2u8_out_t           r;
      u = '{w.unit_0, w.unit_1, w.unit_2, w.unit_3,
            w.unit_4, w.unit_5, w.unit_6, w.unit_7};
      slots = '0;
      pos = 0;
      big = 0;
      r = '0;
      foreach (u[i]) if (u[i] >= TwoByteTop) big = 1;
      if (limit_on && big) begin
        r.exceeded = 1'b1;
        return r;
      end
      foreach (u[i]) begin
        if (u[i] < OneByteTop) begin
          slots[pos*8 +: 8] = u[i][7:0];
          pos += 1;
        end else if (u[i] < TwoByteTop) begin
          slots[pos*8 +: 8]     = {3'b110, u[i][10:6]};
          slots[(pos+1)*8 +: 8] = {2'b10, u[i][5:0]};
          pos += 2;
        end else begin
          slots[pos*8 +: 8]     = {4'b1110, u[i][15:12]};
          slots[(pos+1)*8 +: 8] = {2'b10, u[i][11:6]};
          slots[(pos+2)*8 +: 8] = {2'b10, u[i][5:0]};
          pos += 3;
        end
      end
      r.bytes_low    = slots[63:0];
      r.bytes_middle = slots[127:64];
      r.bytes_high   = slots[191:128];
      r.byte_count   = OffW'(pos);
      return r;
    endfunction

    function void note_word(u2u8_in_t w);
      u2u8_out_t r;
      r = encode_group(w);
      encoded_q.push_back(r);
      words_seen++;
      if (limit_on) limited_words++;
      if (r.exceeded) flagged_words++;
      if (r.byte_count == ByteSlots) full_words++;
    endfunction

    function void check_result(u2u8_out_t got);
      u2u8_out_t want;
      if (encoded_q.size() == 0) begin
        mismatches++;
        if (mismatches <= MaxReports)
          $display("%0t: result word with nothing outstanding: %h", $time, got);
        return;
      end
      want = encoded_q.pop_front();
      words_checked++;
      if (got.bytes_low !== want.bytes_low || got.bytes_middle !== want.bytes_middle ||
          got.bytes_high !== want.bytes_high || got.byte_count !== want.byte_count ||
          got.exceeded !== want.exceeded) begin
        mismatches++;
        if (mismatches <= MaxReports) begin
          $display("%0t: mismatch on result word %0d", $time, words_checked);
          $display("  expected low=%h mid=%h high=%h count=%0d exceeded=%b",
                   want.bytes_low, want.bytes_middle, want.bytes_high,
                   want.byte_count, want.exceeded);
          $display("  actual   low=%h mid=%h high=%h count=%0d exceeded=%b",
                   got.bytes_low, got.bytes_middle, got.bytes_high,
                   got.byte_count, got.exceeded);
        end
      end
    endfunction
  endclass

  logic      clk_i;
  logic      rst_ni;
  logic      start;
  logic      busy;
  u2u8_in_t  in_i;
  logic      cfg_we_i;
  logic      cfg_wdata_i;
  logic      strobe_o;
  u2u8_out_t res_o;

  utf8_scoreboard sb = new();

  utf16_to_utf8_vector_encoder_core DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .in_i        (in_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .strobe_o    (strobe_o),
    .res_o       (res_o)
  );

  initial clk_i = 1'b0;
  always #(ClkHalf) clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (start && !busy) sb.note_word(in_i);
      if (strobe_o) sb.check_result(res_o);
    end
  end

  task automatic send_group(input group_t g);
    u2u8_in_t w;
    w = '{g[0], g[1], g[2], g[3], g[4], g[5], g[6], g[7]};
    start <= 1'b1;
    in_i  <= w;
    do @(posedge clk_i); while (busy);
  endtask

  task automatic pause(input int unsigned cycles);
    start <= 1'b0;
    repeat (cycles) @(posedge clk_i);
  endtask

  task automatic drain_results();
    pause(1);
    while (sb.encoded_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_limit(input bit value);
    drain_results();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    sb.limit_on = value;
  endtask

  function automatic logic [15:0] pick_unit(input bit small_only);
    logic [15:0] edges [11];
    int unsigned kind;
    edges = '{16'h0000, 16'h007F, 16'h0080, 16'h07FF, 16'h0800, 16'hD7FF,
              16'hD800, 16'hDBFF, 16'hDC00, 16'hDFFF, 16'hFFFF};
    kind = $urandom_range(0, 9);
    if (kind <= 2) return 16'($urandom_range(0, OneByteTop - 1));
    if (kind <= 5) return 16'($urandom_range(OneByteTop, TwoByteTop - 1));
    if (kind == 6) return small_only ? edges[$urandom_range(0, 3)] : edges[$urandom_range(0, 10)];
    if (small_only) return 16'($urandom_range(0, TwoByteTop - 1));
    return 16'($urandom_range(TwoByteTop, UnitMax));
  endfunction

  task automatic make_group(input bit small_only, output group_t g);
    int unsigned style;
    style = $urandom_range(0, 7);
    foreach (g[i]) begin
      case (style)
        0: begin
          g[i] = 16'($urandom_range(0, OneByteTop - 1));
        end
        1: begin
          g[i] = small_only ? 16'($urandom_range(OneByteTop, TwoByteTop - 1))
                            : 16'($urandom_range(TwoByteTop, UnitMax));
        end
        2: begin
          g[i] = small_only ? 16'($urandom_range(0, TwoByteTop - 1))
                            : 16'($urandom_range(0, UnitMax));
        end
        default: begin
          g[i] = pick_unit(small_only);
        end
      endcase
    end
  endtask

  task automatic run_random(input bit limit, input int unsigned count, input bit may_idle);
    group_t      g;
    bit          idle_on;
    int unsigned roll;
    write_limit(limit);
    idle_on = 1'b0;
    for (int unsigned n = 0; n < count; n++) begin
      if (n % 40 == 0) idle_on = may_idle && ($urandom_range(0, 1) == 1);
      if (idle_on && $urandom_range(0, 3) == 0) pause($urandom_range(1, 4));
      roll = $urandom_range(0, 9);
      if (!limit || roll == 0) begin
        make_group(1'b0, g);
      end else begin
        make_group(1'b1, g);
        if (roll == 1) g[$urandom_range(0, UnitCount - 1)] = 16'($urandom_range(TwoByteTop, UnitMax));
      end
      send_group(g);
    end
  endtask

  initial begin
    group_t plain [13];
    group_t bounded [8];
    rst_ni      = 1'b0;
    start       = 1'b0;
    in_i        = '0;
    cfg_we_i    = 1'b0;
    cfg_wdata_i = 1'b0;
    plain = '{
      '{16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000},
      '{16'h007F, 16'h007F, 16'h007F, 16'h007F, 16'h007F, 16'h007F, 16'h007F, 16'h007F},
      '{16'h0080, 16'h0080, 16'h0080, 16'h0080, 16'h0080, 16'h0080, 16'h0080, 16'h0080},
      '{16'h07FF, 16'h07FF, 16'h07FF, 16'h07FF, 16'h07FF, 16'h07FF, 16'h07FF, 16'h07FF},
      '{16'h0800, 16'h0800, 16'h0800, 16'h0800, 16'h0800, 16'h0800, 16'h0800, 16'h0800},
      '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF},
      '{16'hD800, 16'hDBFF, 16'hDC00, 16'hDFFF, 16'hD83D, 16'hDE00, 16'hD7FF, 16'hE000},
      '{16'h0041, 16'h00E9, 16'h20AC, 16'h0042, 16'h07FF, 16'h0800, 16'h007F, 16'h0080},
      '{16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000},
      '{16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'hFFFF},
      '{16'hFFFF, 16'h0001, 16'h0001, 16'h0001, 16'h0001, 16'h0001, 16'h0001, 16'h0001},
      '{16'h5555, 16'hAAAA, 16'h0555, 16'h02AA, 16'h0055, 16'h002A, 16'h3C3C, 16'hC3C3},
      '{16'h0001, 16'h0002, 16'h0004, 16'h0008, 16'h0010, 16'h0020, 16'h0040, 16'h0400}
    };
    bounded = '{
      '{16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000},
      '{16'h07FF, 16'h07FF, 16'h07FF, 16'h07FF, 16'h07FF, 16'h07FF, 16'h07FF, 16'h07FF},
      '{16'h0041, 16'h00E9, 16'h007F, 16'h0080, 16'h0400, 16'h0001, 16'h07FF, 16'h0000},
      '{16'h0800, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000},
      '{16'h0041, 16'h0042, 16'h0043, 16'h0044, 16'h0045, 16'h0046, 16'h0047, 16'hFFFF},
      '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF},
      '{16'h07FF, 16'h07FF, 16'h07FF, 16'hD800, 16'h07FF, 16'h07FF, 16'h07FF, 16'h07FF},
      '{16'h0080, 16'h0080, 16'h0080, 16'h0080, 16'h0080, 16'h0080, 16'h0080, 16'h0080}
    };
    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    write_limit(1'b0);
    foreach (plain[i]) send_group(plain[i]);
    write_limit(1'b1);
    foreach (bounded[i]) send_group(bounded[i]);

    run_random(1'b0, 400, 1'b1);
    run_random(1'b1, 300, 1'b1);
    run_random(1'b0, 400, 1'b1);
    run_random(1'b1, 250, 1'b1);
    run_random(1'b0, 250, 1'b0);

    drain_results();
    repeat (DrainCycles) @(posedge clk_i);

    $display("Sent %0d words through both limit settings and checked %0d results.",
             sb.words_seen, sb.words_checked);
    $display("%0d words ran with the limit set, %0d were flagged, %0d filled all 24 bytes.",
             sb.limited_words, sb.flagged_words, sb.full_words);
    if (sb.mismatches == 0 && sb.encoded_q.size() == 0) begin
      $display("** utf16_to_utf8_vector_encoder_core: PASSED **");
    end else begin
      $display("%0d mismatches, %0d results never arrived.", sb.mismatches, sb.encoded_q.size());
      $display("** utf16_to_utf8_vector_encoder_core: FAILED **");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("Timed out with %0d results outstanding.", sb.encoded_q.size());
    $display("** utf16_to_utf8_vector_encoder_core: FAILED **");
    $finish;
  end

endmodule
